@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared types, request and status codes, and parameter defaults for the
// double-ended queue with search
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int REQ_WIDTH    = 3;
  localparam int STATUS_WIDTH = 2;

  // request codes
  localparam logic [REQ_WIDTH-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_POP_BACK   = 3'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_PUSH_FRONT = 3'd2;
  localparam logic [REQ_WIDTH-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_WIDTH-1:0] REQ_SEARCH     = 3'd4;

  // status codes
  localparam logic [STATUS_WIDTH-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH
  } deq_state_t;

endpackage

@@ hw/rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/double_ended_queue_with_search.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// bounded double-ended queue in a ring of DEPTH words with equality search
// ----------------------------------------------------------------------------
// results: a push, a refused push, an empty pop, an empty search and unused codes
//   load the result register straight from the input transfer; a pop reads the
//   ram, then loads it in S_POP; a search reads one stored entry per cycle front to back
// throughput: one item in flight; with out_ready high a push every cycle; after a
//   pop or a search the next request waits until its result is loaded
// reset: clears controller, front index, count and out_valid; ram not cleared
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [deq_pkg::REQ_WIDTH-1:0]     req_type,
  input  logic [DATA_WIDTH-1:0]             value_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [DATA_WIDTH-1:0]             value_out,
  output logic                              found,
  output logic [deq_pkg::STATUS_WIDTH-1:0]  status,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count
);

  localparam int AW = $clog2(DEPTH);      // ring address width
  localparam int CW = $clog2(DEPTH + 1);  // entry count width, holds DEPTH itself
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // ring position of base + off, both already inside the ring
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  // controller state
  deq_pkg::deq_state_t state, state_next;

  // queue pointers
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  // search walk: idx is the offset of the next entry to read
  logic [CW-1:0]         idx, idx_next;
  logic [DATA_WIDTH-1:0] key, key_next;

  // ram port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // result register load
  logic                              res_load;
  logic [DATA_WIDTH-1:0]             res_value;
  logic                              res_found;
  logic [deq_pkg::STATUS_WIDTH-1:0]  res_status;

  logic accept;
  logic is_full;
  logic is_empty;
  logic match;
  logic walk_done;

  assign is_full   = (count == FULL_CNT);
  assign is_empty  = (count == '0);
  assign match     = (ram_rdata == key);
  assign walk_done = (idx == count);

  // new request only when idle and the result slot is free or draining
  assign in_ready = (state == deq_pkg::S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          if ((req_type == deq_pkg::REQ_POP_BACK || req_type == deq_pkg::REQ_POP_FRONT)
              && !is_empty) begin
            state_next = deq_pkg::S_POP;
          end else if (req_type == deq_pkg::REQ_SEARCH && !is_empty) begin
            state_next = deq_pkg::S_SEARCH;
          end
        end
      end
      deq_pkg::S_POP: begin
        state_next = deq_pkg::S_IDLE;
      end
      deq_pkg::S_SEARCH: begin
        if (match || walk_done) begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs of the controller
  always_comb begin
    front_next = front;
    count_next = count;
    idx_next   = idx;
    key_next   = key;
    ram_we     = 1'b0;
    ram_waddr  = ring_add(front, count[AW-1:0]);
    ram_wdata  = value_in;
    ram_re     = 1'b0;
    ram_raddr  = front;
    res_load   = 1'b0;
    res_value  = '0;
    res_found  = 1'b0;
    res_status = deq_pkg::STAT_OK;

    unique case (state)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            deq_pkg::REQ_PUSH_BACK: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = deq_pkg::STAT_FULL;
              end else begin
                // back slot sits count places past the front
                ram_we     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            deq_pkg::REQ_PUSH_FRONT: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = deq_pkg::STAT_FULL;
              end else begin
                front_next = ring_add(front, LAST_POS);  // step back one place
                ram_we     = 1'b1;
                ram_waddr  = front_next;
                count_next = count + 1'b1;
              end
            end
            deq_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = deq_pkg::STAT_EMPTY;
              end else begin
                count_next = count - 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = ring_add(front, count_next[AW-1:0]);
              end
            end
            deq_pkg::REQ_POP_FRONT: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = deq_pkg::STAT_EMPTY;
              end else begin
                count_next = count - 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = front;
                front_next = ring_add(front, AW'(1));
              end
            end
            deq_pkg::REQ_SEARCH: begin
              if (is_empty) begin
                res_load = 1'b1;
              end else begin
                // fetch the front entry, walk continues from offset one
                ram_re    = 1'b1;
                ram_raddr = front;
                idx_next  = CW'(1);
                key_next  = value_in;
              end
            end
            default: begin
              // unused codes answer with the current count only
              res_load = 1'b1;
            end
          endcase
        end
      end
      deq_pkg::S_POP: begin
        res_load  = 1'b1;
        res_value = ram_rdata;
      end
      deq_pkg::S_SEARCH: begin
        if (match) begin
          res_load  = 1'b1;
          res_found = 1'b1;
        end else if (walk_done) begin
          res_load = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ring_add(front, idx[AW-1:0]);
          idx_next  = idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
      front <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // search key holds for the whole walk
  always_ff @(posedge clk) begin
    key <= key_next;
  end

  // result register: parts the controller from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_out   <= res_value;
      found       <= res_found;
      status      <= res_status;
      entry_count <= count_next;
    end
  end

endmodule

@@ hw/rtl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks of the double-ended queue results, bound to the top level
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [DATA_WIDTH-1:0]             value_out,
  input logic                              found,
  input logic [deq_pkg::STATUS_WIDTH-1:0]  status,
  input logic [$clog2(DEPTH+1)-1:0]        entry_count
);

  localparam logic [$clog2(DEPTH+1)-1:0] FULL_CNT = ($clog2(DEPTH+1))'(DEPTH);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(found)
      && $stable(status) && $stable(entry_count))
    else $error("result changed while stalled");

  // count never exceeds the ring size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= FULL_CNT)
    else $error("entry count beyond depth");

  // a refused push only happens on a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == deq_pkg::STAT_FULL |-> entry_count == FULL_CNT && value_out == '0)
    else $error("full status with room left");

  // an empty pop leaves nothing and returns zero
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == deq_pkg::STAT_EMPTY |-> entry_count == '0 && value_out == '0
      && !found)
    else $error("empty status with entries present");

  // a hit is never reported together with an error status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == deq_pkg::STAT_OK && entry_count != '0)
    else $error("found flag on a failed request");

endmodule

bind double_ended_queue_with_search deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .value_out   (value_out),
  .found       (found),
  .status      (status),
  .entry_count (entry_count)
);

@@ test/deq_result_checker.sv @@
// ----------------------------------------------------------------------------
// deq_result_checker
// watches both channels of the double-ended queue, predicts each result from
// its own copy of the ring and compares it field by field
// ----------------------------------------------------------------------------
module deq_result_checker #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [deq_pkg::REQ_WIDTH-1:0]     req_type,
  input  logic [DATA_WIDTH-1:0]             value_in,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [DATA_WIDTH-1:0]             value_out,
  input  logic                              found,
  input  logic [deq_pkg::STATUS_WIDTH-1:0]  status,
  input  logic [$clog2(DEPTH+1)-1:0]        entry_count,
  output int                                fail_count,
  output int                                pending
);

  localparam int CW = $clog2(DEPTH+1);

  typedef struct packed {
    logic [DATA_WIDTH-1:0]            popped;
    logic                             hit;
    logic [deq_pkg::STATUS_WIDTH-1:0] code;
    logic [CW-1:0]                    entries;
  } deq_result_t;

  // shadow of the ring
  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  int                    head_slot;
  int                    fill_level;

  deq_result_t expected_results [$];
  deq_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    head_slot  = 0;
    fill_level = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    $display("%0t deq check: %s: got %0h, expected %0h", $time, what, got, wanted);
    fail_count++;
  endtask

  function automatic deq_result_t apply_request(input logic [deq_pkg::REQ_WIDTH-1:0] kind,
                                                input logic [DATA_WIDTH-1:0] operand);
    deq_result_t res;
    int          slot;
    res = '0;
    case (kind)
      deq_pkg::REQ_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          res.code = deq_pkg::STAT_FULL;
        end else begin
          ring_words[(head_slot + fill_level) % DEPTH] = operand;
          fill_level++;
        end
      end
      deq_pkg::REQ_PUSH_FRONT: begin
        if (fill_level >= DEPTH) begin
          res.code = deq_pkg::STAT_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          ring_words[head_slot] = operand;
          fill_level++;
        end
      end
      deq_pkg::REQ_POP_BACK: begin
        if (fill_level == 0) begin
          res.code = deq_pkg::STAT_EMPTY;
        end else begin
          res.popped = ring_words[(head_slot + fill_level - 1) % DEPTH];
          fill_level--;
        end
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (fill_level == 0) begin
          res.code = deq_pkg::STAT_EMPTY;
        end else begin
          res.popped = ring_words[head_slot];
          head_slot  = (head_slot + 1) % DEPTH;
          fill_level--;
        end
      end
      deq_pkg::REQ_SEARCH: begin
        for (slot = 0; slot < fill_level; slot++) begin
          if (ring_words[(head_slot + slot) % DEPTH] == operand) res.hit = 1'b1;
        end
      end
      default: ;
    endcase
    res.entries = fill_level[CW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head_slot  = 0;
      fill_level = 0;
      expected_results.delete();
    end else begin
      // a result can never leave on the edge that takes its request
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", value_out, 0);
        end else begin
          want = expected_results.pop_front();
          if (value_out !== want.popped) report_mismatch("value_out", value_out, want.popped);
          if (found !== want.hit) report_mismatch("found", found, want.hit);
          if (status !== want.code) report_mismatch("status", status, want.code);
          if (entry_count !== want.entries)
            report_mismatch("entry_count", entry_count, want.entries);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_request(req_type, value_in));
    end
    pending <= expected_results.size();
  end

endmodule

@@ test/double_ended_queue_with_search_test.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_test
// drives push, pop and search requests into the double-ended queue with
// random gaps on both channels; a checker beside the block predicts and
// compares every result
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_test;

  localparam int DEPTH      = deq_pkg::DEPTH_DEFAULT;
  localparam int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT;
  localparam int CW         = $clog2(DEPTH+1);

  // request codes the block has no meaning for
  localparam logic [deq_pkg::REQ_WIDTH-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [deq_pkg::REQ_WIDTH-1:0] REQ_UNUSED_HI = 3'd7;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [deq_pkg::REQ_WIDTH-1:0]    req_type;
  logic [DATA_WIDTH-1:0]            value_in;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [DATA_WIDTH-1:0]            value_out;
  logic                             found;
  logic [deq_pkg::STATUS_WIDTH-1:0] status;
  logic [CW-1:0]                    entry_count;

  int fail_count;
  int pending;

  // percent of cycles each side holds back
  int send_idle = 38;
  int recv_idle = 48;

  // recently pushed values, so searches often hit
  logic [DATA_WIDTH-1:0] recent_pushes [$];

  double_ended_queue_with_search #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_out   (value_out),
    .found       (found),
    .status      (status),
    .entry_count (entry_count)
  );

  deq_result_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_out   (value_out),
    .found       (found),
    .status      (status),
    .entry_count (entry_count),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random, one decision per edge
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("double_ended_queue_with_search_test: done, errors");
    $finish;
  end

  // one request; valid stays up until the transfer, gaps come before it
  task automatic send_request(input logic [deq_pkg::REQ_WIDTH-1:0] kind,
                              input logic [DATA_WIDTH-1:0] operand);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    value_in <= operand;
    @(posedge clk);
    // in_ready read right after the edge is the value the edge saw
    while (!in_ready) @(posedge clk);
    if (kind == deq_pkg::REQ_PUSH_BACK || kind == deq_pkg::REQ_PUSH_FRONT) begin
      recent_pushes.push_back(operand);
      if (recent_pushes.size() > 32) void'(recent_pushes.pop_front());
    end
  endtask

  // zero, all ones, small values that collide, or anything
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DATA_WIDTH'($urandom_range(15));
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // random traffic in bursts that lean toward filling, draining or neither,
  // so the queue swings between empty and full
  task automatic run_traffic(input int n_items);
    int                            lean;
    int                            roll;
    logic [deq_pkg::REQ_WIDTH-1:0] kind;
    logic [DATA_WIDTH-1:0]         operand;
    lean = 2;
    for (int k = 0; k < n_items; k++) begin
      if (k % 24 == 0) lean = $urandom_range(2);
      roll    = $urandom_range(99);
      operand = pick_value();
      if (roll < 3) begin
        kind = REQ_UNUSED_LO + deq_pkg::REQ_WIDTH'($urandom_range(2));
      end else if (roll < 16) begin
        kind = deq_pkg::REQ_SEARCH;
        if (recent_pushes.size() != 0 && $urandom_range(1) == 1)
          operand = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
      end else begin
        roll = $urandom_range(99);
        if ((lean == 0 && roll < 75) || (lean == 1 && roll < 25) || (lean == 2 && roll < 50))
          kind = $urandom_range(1) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK;
        else
          kind = $urandom_range(1) ? deq_pkg::REQ_POP_FRONT : deq_pkg::REQ_POP_BACK;
      end
      send_request(kind, operand);
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = deq_pkg::REQ_PUSH_BACK;
    value_in = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty queue: both pops, a search and unused codes
    send_request(deq_pkg::REQ_POP_BACK, '1);
    send_request(deq_pkg::REQ_POP_FRONT, '0);
    send_request(deq_pkg::REQ_SEARCH, '0);
    send_request(REQ_UNUSED_LO, '1);
    send_request(REQ_UNUSED_HI, 32'h5a5a_a5a5);

    // one entry: find it, then pop the last entry away
    send_request(deq_pkg::REQ_PUSH_BACK, '1);
    send_request(deq_pkg::REQ_SEARCH, '1);
    send_request(deq_pkg::REQ_POP_FRONT, '0);

    // fill from both ends, then push into a full queue at each end
    for (int k = 0; k < DEPTH; k++) begin
      send_request((k % 2 == 0) ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK,
                   (k == 0) ? '0 : DATA_WIDTH'(32'h8000_0001 ^ (k << 7)));
    end
    send_request(deq_pkg::REQ_PUSH_BACK, 32'h1234_5678);
    send_request(deq_pkg::REQ_PUSH_FRONT, '1);

    // random traffic with both sides stalling, then swapped, then flat out
    run_traffic(375);
    send_idle = 48;
    recv_idle = 38;
    run_traffic(375);
    send_idle = 0;
    recv_idle = 0;
    run_traffic(375);

    // drain, then give a stray result time to show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("double_ended_queue_with_search_test: done, clean");
    end else begin
      $display("double_ended_queue_with_search_test: done, errors");
    end
    $finish;
  end

endmodule
